// File: design/hash_insert_linear_probe_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash insert block
// Clocked assertion helpers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef HASH_INSERT_LINEAR_PROBE_MACROS_SVH
`define HASH_INSERT_LINEAR_PROBE_MACROS_SVH

// Property checked on every rising aclk edge, off while aresetn is low.
`define HILP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication on the same edge.
`define HILP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Implication with the consequent checked in the next cycle.
`define HILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: design/hilp_pkg.sv
// ----------------------------------------------------------------------------
// hilp_pkg
// Types and codes of the linear probing hash insert block.
// ----------------------------------------------------------------------------
package hilp_pkg;

    localparam int ID_W      = 14;
    localparam int PAYLOAD_W = 5;
    localparam int LINK_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int OUT_SLOT_W = 6;

    localparam logic [ID_W-1:0]   ID_MIN    = 14'd1000;
    localparam logic [ID_W-1:0]   ID_MAX    = 14'd9999;
    localparam logic [ID_W-1:0]   ID_EMPTY  = 14'd0;
    localparam logic [LINK_W-1:0] LINK_NONE = 6'd63;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED_HOME = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED_PROBE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ID      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] payload;   // {blood_group, rhesus_negative, composition}
        logic [LINK_W-1:0]    link;
    } slot_word_t;

    localparam int WORD_W = $bits(slot_word_t);

endpackage

// File: design/hilp_ram.sv
// ----------------------------------------------------------------------------
// hilp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hilp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/hash_insert_linear_probe.sv
// ----------------------------------------------------------------------------
// hash_insert_linear_probe
// Record table with linear probing insert, held in one slot RAM.
// ----------------------------------------------------------------------------
// The block keeps TABLE_SLOTS record slots in a single RAM word per slot
// (ID, packed payload, synonym link). It handles one item at a time and
// returns exactly one result per item. An insert takes ID mod TABLE_SLOTS
// as home slot (reciprocal multiply, back multiply, one correction), then
// reads one slot per cycle from the home slot onward until an empty one
// turns up or the probe wraps back to home (table full). On an empty slot
// it writes the record and, after a collision, the home slot's link. A bad
// ID goes straight to the result; a clear writes every slot empty. The slot
// RAM read port, one slot per cycle, sets the insert time. After reset the
// block runs a clearing pass over all TABLE_SLOTS slots with s_ready low.
// The result sits in an output register, so the next item is taken while
// the result waits for m_ready.
// ----------------------------------------------------------------------------
module hash_insert_linear_probe
    import hilp_pkg::*;
#(
    parameter int TABLE_SLOTS = 53
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input items
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_command,
    input  logic [ID_W-1:0]       s_bag_id,
    input  logic [1:0]            s_blood_group,
    input  logic                  s_rhesus_negative,
    input  logic [1:0]            s_composition,
    // result items
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [OUT_SLOT_W-1:0] m_stored_slot,
    output logic [OUT_SLOT_W-1:0] m_home_slot
);

    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    // ID mod TABLE_SLOTS: quotient estimate from a fixed point reciprocal.
    // With a 28 bit shift and 14 bit IDs the estimate is low by at most one.
    localparam int RECIP_SHIFT = 28;
    localparam int PROD_W      = ID_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP =
        RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [ID_W-1:0]   SLOTS_ID  = ID_W'(TABLE_SLOTS);

    typedef enum logic [3:0] {
        S_INIT,     // clearing pass after reset
        S_IDLE,
        S_MUL,      // id * reciprocal
        S_SUB,      // id - quotient * slots
        S_MOD,      // final correction, issue home slot read
        S_PROBE,    // one slot checked per cycle
        S_WRITE,    // store record in target slot
        S_LINK,     // point home slot at target
        S_CLEAR,    // clear command sweep
        S_FINISH    // hand result to output register
    } state_t;

    state_t                 state_reg;
    logic [SLOT_W-1:0]      cnt_reg;
    logic [ID_W-1:0]        id_reg;
    logic [PAYLOAD_W-1:0]   payload_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ID_W-1:0]        rem_reg;
    logic [SLOT_W-1:0]      home_reg;
    logic [SLOT_W-1:0]      probe_reg;
    logic                   first_reg;
    slot_word_t             home_word_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic [OUT_SLOT_W-1:0]  res_stored_reg;
    logic [OUT_SLOT_W-1:0]  res_home_reg;
    logic                   m_valid_reg;
    logic [STATUS_W-1:0]    m_status_reg;
    logic [OUT_SLOT_W-1:0]  m_stored_reg;
    logic [OUT_SLOT_W-1:0]  m_home_reg;

    logic [ID_W-1:0]        quot;
    logic [SLOT_W-1:0]      home_next;
    logic [SLOT_W-1:0]      probe_next;
    logic                   id_bad;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    slot_word_t             ram_wdata;
    logic [SLOT_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;
    slot_word_t             rd_word;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_stored_slot = m_stored_reg;
    assign m_home_slot   = m_home_reg;

    assign id_bad  = (s_bag_id < ID_MIN) || (s_bag_id > ID_MAX);
    assign quot    = prod_reg[RECIP_SHIFT +: ID_W];
    assign rd_word = slot_word_t'(ram_rdata);

    // Remainder is below twice the table size here: one conditional subtract.
    always_comb begin
        if (rem_reg >= SLOTS_ID) begin
            home_next = SLOT_W'(rem_reg - SLOTS_ID);
        end else begin
            home_next = SLOT_W'(rem_reg);
        end
    end

    // Next probe slot, wrapping at the table end.
    always_comb begin
        if (probe_reg == LAST_SLOT) begin
            probe_next = '0;
        end else begin
            probe_next = probe_reg + 1'b1;
        end
    end

    // Slot RAM port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = '{id: ID_EMPTY, payload: '0, link: LINK_NONE};
        ram_raddr = probe_next;
        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_MOD: begin
                ram_raddr = home_next;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = probe_reg;
                ram_wdata = '{id: id_reg, payload: payload_reg, link: LINK_NONE};
            end
            S_LINK: begin
                // home word was captured on the first probe and is unchanged since
                ram_we         = 1'b1;
                ram_waddr      = home_reg;
                ram_wdata      = home_word_reg;
                ram_wdata.link = LINK_W'(probe_reg);
            end
            default: begin
            end
        endcase
    end

    hilp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer, result staging and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // in S_FINISH the output register is refilled below instead
            if (m_valid_reg && m_ready && (state_reg != S_FINISH)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT: begin
                    if (cnt_reg == LAST_SLOT) begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        id_reg      <= s_bag_id;
                        payload_reg <= {s_blood_group, s_rhesus_negative, s_composition};
                        if (s_command == CMD_CLEAR) begin
                            cnt_reg   <= '0;
                            state_reg <= S_CLEAR;
                        end else if (id_bad) begin
                            res_status_reg <= ST_BAD_ID;
                            res_stored_reg <= '0;
                            res_home_reg   <= '0;
                            state_reg      <= S_FINISH;
                        end else begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    prod_reg  <= PROD_W'(id_reg) * PROD_W'(RECIP);
                    state_reg <= S_SUB;
                end
                S_SUB: begin
                    rem_reg   <= id_reg - ID_W'(quot * SLOTS_ID);
                    state_reg <= S_MOD;
                end
                S_MOD: begin
                    home_reg  <= home_next;
                    probe_reg <= home_next;
                    first_reg <= 1'b1;
                    state_reg <= S_PROBE;
                end
                S_PROBE: begin
                    first_reg <= 1'b0;
                    if (first_reg) begin
                        home_word_reg <= rd_word;
                    end
                    if (rd_word.id == ID_EMPTY) begin
                        state_reg <= S_WRITE;
                    end else if (probe_next == home_reg) begin
                        // wrapped back to home: no empty slot
                        res_status_reg <= ST_FULL;
                        res_stored_reg <= '0;
                        res_home_reg   <= OUT_SLOT_W'(home_reg);
                        state_reg      <= S_FINISH;
                    end else begin
                        probe_reg <= probe_next;
                    end
                end
                S_WRITE: begin
                    res_stored_reg <= OUT_SLOT_W'(probe_reg);
                    res_home_reg   <= OUT_SLOT_W'(home_reg);
                    if (probe_reg == home_reg) begin
                        res_status_reg <= ST_STORED_HOME;
                        state_reg      <= S_FINISH;
                    end else begin
                        res_status_reg <= ST_STORED_PROBE;
                        state_reg      <= S_LINK;
                    end
                end
                S_LINK: begin
                    state_reg <= S_FINISH;
                end
                S_CLEAR: begin
                    if (cnt_reg == LAST_SLOT) begin
                        cnt_reg        <= '0;
                        res_status_reg <= ST_CLEARED;
                        res_stored_reg <= '0;
                        res_home_reg   <= '0;
                        state_reg      <= S_FINISH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status_reg;
                        m_stored_reg <= res_stored_reg;
                        m_home_reg   <= res_home_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: design/hilp_checker.sv
// ----------------------------------------------------------------------------
// hilp_checker
// Port level checks of the hash insert block, bound to the top level.
// ----------------------------------------------------------------------------
`include "hash_insert_linear_probe_macros.svh"

module hilp_checker
    import hilp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  s_command,
    input logic [ID_W-1:0]       s_bag_id,
    input logic [1:0]            s_blood_group,
    input logic                  s_rhesus_negative,
    input logic [1:0]            s_composition,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [STATUS_W-1:0]   m_status,
    input logic [OUT_SLOT_W-1:0] m_stored_slot,
    input logic [OUT_SLOT_W-1:0] m_home_slot
);

    // stalled result holds
    `HILP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_status) && $stable(m_stored_slot) && $stable(m_home_slot),
        "stalled result changed")

    // one item in flight: an accepted item leaves the input side busy
    `HILP_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready,
        "input ready right after accept")

    `HILP_ASSERT_IMP(a_home_match,
        m_valid && (m_status == ST_STORED_HOME), m_stored_slot == m_home_slot,
        "home store with stored slot not equal home slot")

    `HILP_ASSERT_IMP(a_no_slot,
        m_valid && (m_status == ST_BAD_ID || m_status == ST_CLEARED),
        m_stored_slot == '0 && m_home_slot == '0,
        "bad ID or clear result with nonzero slot")

    `HILP_ASSERT_IMP(a_full_unstored,
        m_valid && (m_status == ST_FULL), m_stored_slot == '0,
        "full table result with stored slot")

endmodule

bind hash_insert_linear_probe hilp_checker u_hilp_checker (.*);

// File: sim/tb_hash_insert_linear_probe.sv
// ----------------------------------------------------------------------------
// tb_hash_insert_linear_probe
// Self-checking bench for the linear probing record table. A shadow table
// predicts each outcome, and a queue of predicted placements is matched
// against the result channel item by item. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_hash_insert_linear_probe
    import hilp_pkg::*;
;

    localparam int TABLE_SLOTS    = 53;
    localparam int CLK_PERIOD     = 4;
    localparam int RANDOM_ITEMS   = 1150;
    // a full-table insert reads every slot; also covers the clear time
    localparam int SETTLE_CYCLES  = TABLE_SLOTS + 16;
    localparam int DRAIN_LIMIT    = 5000;
    localparam int TIMEOUT_CYCLES = 800_000;

    // one predicted result item
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_SLOT_W-1:0] stored_slot;
        logic [OUT_SLOT_W-1:0] home_slot;
    } placement_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_command;
    logic [ID_W-1:0]       s_bag_id;
    logic [1:0]            s_blood_group;
    logic                  s_rhesus_negative;
    logic [1:0]            s_composition;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [OUT_SLOT_W-1:0] m_stored_slot;
    logic [OUT_SLOT_W-1:0] m_home_slot;

    // shadow copy of the slot RAM and the placements still owed by the block
    slot_word_t shadow_slots [TABLE_SLOTS];
    placement_t placement_q[$];

    int fail_count      = 0;
    int items_sent      = 0;
    int sender_gap_mode = 1;    // 0: back-to-back items, 1: random gaps

    // receiver pacing
    int rx_hold_request = 0;    // set by a test, picked up by the pacing process
    int rx_hold_left    = 0;
    int rx_run_left     = 0;
    int rx_stall_left   = 0;
    int rx_pick;

    hash_insert_linear_probe #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_bag_id         (s_bag_id),
        .s_blood_group    (s_blood_group),
        .s_rhesus_negative(s_rhesus_negative),
        .s_composition    (s_composition),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_stored_slot    (m_stored_slot),
        .m_home_slot      (m_home_slot)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shadow table
    // ------------------------------------------------------------------------
    function automatic void wipe_slots();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            shadow_slots[i] = '{id: ID_EMPTY, payload: '0, link: LINK_NONE};
        end
    endfunction

    // Applies one item to the shadow table and returns where the record lands.
    function automatic placement_t place_record(input logic cmd,
                                                input logic [ID_W-1:0] bag_id,
                                                input logic [1:0] grp,
                                                input logic rh,
                                                input logic [1:0] comp);
        placement_t res;
        int home;
        int target;
        res = '{status: ST_BAD_ID, stored_slot: '0, home_slot: '0};
        if (cmd == CMD_CLEAR) begin
            wipe_slots();
            res.status = ST_CLEARED;
            return res;
        end
        // out-of-range IDs (incl. 14-bit patterns above 9999) touch nothing
        if (bag_id < ID_MIN || bag_id > ID_MAX) begin
            return res;
        end
        home   = int'(bag_id) % TABLE_SLOTS;
        target = home;
        // probe forward with wrap; coming back to home means no room at all
        while (shadow_slots[target].id != ID_EMPTY) begin
            target = (target + 1) % TABLE_SLOTS;
            if (target == home) begin
                res.status    = ST_FULL;
                res.home_slot = OUT_SLOT_W'(home);
                return res;
            end
        end
        // collision: home link is overwritten even if it already pointed somewhere
        if (target != home) begin
            shadow_slots[home].link = LINK_W'(target);
        end
        shadow_slots[target] = '{id: bag_id, payload: {grp, rh, comp}, link: LINK_NONE};
        res.status      = (target == home) ? ST_STORED_HOME : ST_STORED_PROBE;
        res.stored_slot = OUT_SLOT_W'(target);
        res.home_slot   = OUT_SLOT_W'(home);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // ID pickers
    // ------------------------------------------------------------------------
    function automatic logic [ID_W-1:0] random_valid_id();
        return ID_W'($urandom_range(int'(ID_MIN), int'(ID_MAX)));
    endfunction

    // Valid ID whose home slot is h.
    function automatic logic [ID_W-1:0] id_for_home(input int h);
        int k_lo;
        int k_hi;
        k_lo = (int'(ID_MIN) - h + TABLE_SLOTS - 1) / TABLE_SLOTS;
        k_hi = (int'(ID_MAX) - h) / TABLE_SLOTS;
        return ID_W'(h + TABLE_SLOTS * $urandom_range(k_lo, k_hi));
    endfunction

    function automatic logic [ID_W-1:0] random_bad_id();
        if ($urandom_range(0, 1) == 0) begin
            return ID_W'($urandom_range(0, int'(ID_MIN) - 1));
        end
        return ID_W'($urandom_range(int'(ID_MAX) + 1, (1 << ID_W) - 1));
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (sender_gap_mode == 0) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // Called and returns at a rising edge. Valid is left high after the
    // accept, so a following item with no gap keeps it high without a dip.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] bag_id,
                             input logic [1:0] grp, input logic rh,
                             input logic [1:0] comp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_bag_id          <= bag_id;
        s_blood_group     <= grp;
        s_rhesus_negative <= rh;
        s_composition     <= comp;
        // ready is sampled mid-cycle; high there means accepted at the next edge
        do @(negedge aclk); while (s_ready !== 1'b1);
        @(posedge aclk);
        placement_q.push_back(place_record(cmd, bag_id, grp, rh, comp));
        items_sent++;
    endtask

    task automatic send_insert(input logic [ID_W-1:0] bag_id);
        send_item(CMD_INSERT, bag_id, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)));
    endtask

    task automatic send_clear();
        send_item(CMD_CLEAR, ID_W'($urandom_range(0, (1 << ID_W) - 1)),
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                  2'($urandom_range(0, 3)));
    endtask

    // sender pause: valid drops, nothing new until every owed result is back
    task automatic wait_for_results();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (placement_q.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (placement_q.size() != 0) begin
            $error("%0d result items never arrived", placement_q.size());
            fail_count++;
            placement_q.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: long free runs, short stalls, a few long stalls, and
    // a forced hold-off when a test asks for one.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_hold_request > 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_ready <= 1'b0;
        end else if (rx_run_left > 0) begin
            rx_run_left--;
            m_ready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 20) begin
                rx_run_left = $urandom_range(20, 150);
            end else begin
                rx_run_left   = $urandom_range(0, 7);
                rx_stall_left = (rx_pick < 90) ? $urandom_range(1, 3)
                                               : $urandom_range(10, 40);
            end
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: sampled mid-cycle, so the accept at the next edge is known
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(negedge aclk) begin
        placement_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (placement_q.size() == 0) begin
                $error("result item with no input item pending (status %0d)", m_status);
                fail_count++;
            end else begin
                want = placement_q.pop_front();
                check_field("status", 8'(want.status), 8'(m_status));
                check_field("stored_slot", 8'(want.stored_slot), 8'(m_stored_slot));
                check_field("home_slot", 8'(want.home_slot), 8'(m_home_slot));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Range edges, field extremes, collisions, wrap past the last slot,
    // home link overwrite, duplicates and clear.
    task automatic test_directed();
        send_item(CMD_INSERT, ID_MIN, 2'd0, 1'b0, 2'd0);                // home 46
        send_item(CMD_INSERT, ID_MAX, 2'd3, 1'b1, 2'd3);                // home 35
        send_item(CMD_INSERT, ID_W'(ID_MIN - 1), 2'd1, 1'b0, 2'd2);     // just below range
        send_item(CMD_INSERT, ID_W'(ID_MAX + 1), 2'd2, 1'b1, 2'd1);     // just above range
        send_item(CMD_INSERT, ID_EMPTY, 2'd0, 1'b0, 2'd0);              // zero ID
        send_item(CMD_INSERT, '1, 2'd3, 1'b1, 2'd3);                    // all ones
        send_item(CMD_INSERT, ID_W'(ID_MIN + TABLE_SLOTS), 2'd1, 1'b1, 2'd1); // collides at 46
        send_item(CMD_INSERT, id_for_home(TABLE_SLOTS - 1), 2'd2, 1'b0, 2'd2);
        // two more on the last slot: first wraps to slot 0, second lands on 1
        // and rewrites the home link
        send_item(CMD_INSERT, id_for_home(TABLE_SLOTS - 1), 2'd3, 1'b0, 2'd1);
        send_item(CMD_INSERT, id_for_home(TABLE_SLOTS - 1), 2'd0, 1'b1, 2'd3);
        send_item(CMD_INSERT, id_for_home(0), 2'd1, 1'b0, 2'd0);        // 0 taken by a record homed at the last slot
        send_item(CMD_INSERT, ID_MIN, 2'd2, 1'b1, 2'd2);                // duplicate ID
        send_item(CMD_INSERT, 14'd8192, 2'd1, 1'b0, 2'd3);              // top ID bit set
        send_item(CMD_CLEAR, ID_MIN, 2'd3, 1'b1, 2'd3);
        send_item(CMD_CLEAR, '1, 2'd0, 1'b0, 2'd0);                     // clear of empty table
        send_item(CMD_INSERT, ID_MIN, 2'd0, 1'b1, 2'd1);                // home again after clear
        send_item(CMD_INSERT, ID_MIN, 2'd3, 1'b0, 2'd2);
        wait_for_results();
    endtask

    // Every fill insert homes to slot 0, so probe length grows to the whole table;
    // then the table is full for valid IDs, still answers bad IDs, and clears.
    task automatic test_fill_until_full();
        send_clear();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_insert(id_for_home(0));
        end
        send_insert(id_for_home(0));
        send_insert(id_for_home(TABLE_SLOTS - 1));
        send_insert(random_valid_id());
        send_insert(random_bad_id());
        send_clear();
        send_insert(id_for_home(0));
        wait_for_results();
    endtask

    // Receiver holds off while items keep coming back to back: the output
    // register fills and the block stops taking items. Then a full drain.
    task automatic test_result_backpressure();
        sender_gap_mode = 0;
        rx_hold_request = 300;
        repeat (12) send_insert(id_for_home($urandom_range(40, TABLE_SLOTS - 1)));
        wait_for_results();
        sender_gap_mode = 1;
    endtask

    // Mostly fill runs (often clustered to force long probes and wraps, often
    // long enough to fill the table), mixed with bad IDs, clears and pauses.
    task automatic test_random_sequences(input int n_items);
        int stop_at;
        int kind;
        int run_len;
        int center;
        bit clustered;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            sender_gap_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
            if ($urandom_range(0, 6) == 0) begin
                wait_for_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_clear();
                end
                run_len   = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 70)
                                                        : $urandom_range(1, 40);
                clustered = 1'($urandom_range(0, 1));
                center    = ($urandom_range(0, 3) == 0) ? $urandom_range(45, TABLE_SLOTS - 1)
                                                        : $urandom_range(0, TABLE_SLOTS - 1);
                for (int i = 0; i < run_len; i++) begin
                    if (clustered) begin
                        send_insert(id_for_home((center + $urandom_range(0, 3)) % TABLE_SLOTS));
                    end else begin
                        send_insert(random_valid_id());
                    end
                end
            end else if (kind < 90) begin
                run_len = $urandom_range(1, 8);
                for (int i = 0; i < run_len; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_clear();
                    end else if ($urandom_range(0, 1) == 0) begin
                        send_insert(random_bad_id());
                    end else begin
                        send_insert(ID_W'($urandom_range(0, (1 << ID_W) - 1)));
                    end
                end
            end else begin
                send_clear();
            end
        end
        sender_gap_mode = 1;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn           <= 1'b0;
        s_valid           <= 1'b0;
        s_command         <= CMD_INSERT;
        s_bag_id          <= '0;
        s_blood_group     <= '0;
        s_rhesus_negative <= 1'b0;
        s_composition     <= '0;
        wipe_slots();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        // the post-reset clearing pass shows up as s_ready low; send_item waits it out

        test_directed();
        test_fill_until_full();
        test_result_backpressure();
        test_random_sequences(RANDOM_ITEMS);

        wait_for_results();
        // nothing more should come out
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/hilp_pkg.sv
design/hilp_ram.sv
design/hash_insert_linear_probe.sv
design/hilp_checker.sv
sim/tb_hash_insert_linear_probe.sv
